// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int CELLS    = COLUMNS * ROWS;
	localparam int LAST_ROW = (ROWS - 1) * COLUMNS;

	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int CUR_W  = 11;
	localparam int CELL_W = 11;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;

	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW_A = ADDR_W'(LAST_ROW);
	localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
	localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_BLANK
	} state_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CHAR_W-1:0] char_code;
		logic [CELL_W-1:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] raddr;
		logic              chr_we;
		logic              atr_we;
		logic [ADDR_W-1:0] waddr;
		logic [CHAR_W-1:0] chr_wdata;
		logic [ATTR_W-1:0] atr_wdata;
	} mem_req_t;

	typedef struct packed {
		logic              load;
		logic [CUR_W-1:0]  cursor;
		logic [CHAR_W-1:0] rchar;
		logic [ATTR_W-1:0] rattr;
		logic              scrolled;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/tcw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2000,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/tcw_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tcw_seq (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tcw_pkg::req_t             req,
	input  wire logic                      in_fire,
	input  wire logic [tcw_pkg::ATTR_W-1:0] attr,
	input  wire logic [tcw_pkg::CHAR_W-1:0] chr_rdata,
	input  wire logic [tcw_pkg::ATTR_W-1:0] atr_rdata,
	output logic                           busy,
	output tcw_pkg::mem_req_t              mem,
	output tcw_pkg::result_t               res
);

	tcw_pkg::state_t state_q, state_d;

	logic [tcw_pkg::ADDR_W-1:0] ptr_q;
	logic [tcw_pkg::ADDR_W-1:0] cur_q;
	logic [tcw_pkg::COL_W-1:0]  col_q;
	logic [tcw_pkg::ROW_W-1:0]  row_q;
	logic                       scr_q;
	logic                       oor_q;
	logic                       copy_s1;
	logic [tcw_pkg::ADDR_W-1:0] copy_addr_s1;

	logic                       is_nl;
	logic                       wrap;
	logic                       scroll_w;
	logic                       in_range;
	logic [tcw_pkg::ADDR_W-1:0] cur_inc;
	logic [tcw_pkg::ADDR_W-1:0] cur_nl;

	assign is_nl    = (req.char_code == tcw_pkg::NEWLINE_CODE);
	assign wrap     = is_nl || (col_q == tcw_pkg::COL_LAST);
	assign scroll_w = wrap && (row_q == tcw_pkg::ROW_LAST);
	assign in_range = (int'(req.cell_index) < tcw_pkg::CELLS);
	assign cur_inc  = cur_q + tcw_pkg::ADDR_W'(1);
	assign cur_nl   = cur_q + tcw_pkg::COLS_A - tcw_pkg::ADDR_W'(col_q);
	assign busy     = (state_q != tcw_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				if (ptr_q == tcw_pkg::LAST_CELL) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (in_fire) begin
					unique case (req.kind)
						tcw_pkg::KIND_WRITE: begin
							if (scroll_w) state_d = tcw_pkg::ST_COPY;
						end
						tcw_pkg::KIND_CLEAR: state_d = tcw_pkg::ST_BLANK;
						tcw_pkg::KIND_READ:  state_d = tcw_pkg::ST_READ;
						default: ;
					endcase
				end
			end
			tcw_pkg::ST_READ: state_d = tcw_pkg::ST_IDLE;
			tcw_pkg::ST_COPY: begin
				if (ptr_q == tcw_pkg::LAST_CELL) state_d = tcw_pkg::ST_BLANK;
			end
			tcw_pkg::ST_BLANK: begin
				if (!copy_s1 && ptr_q == tcw_pkg::LAST_CELL) state_d = tcw_pkg::ST_IDLE;
			end
			default: state_d = tcw_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		mem       = '0;
		res       = '0;
		mem.raddr = (state_q == tcw_pkg::ST_COPY) ? ptr_q : tcw_pkg::ADDR_W'(req.cell_index);
		// pending scroll copy owns the char port
		if (copy_s1) begin
			mem.chr_we    = 1'b1;
			mem.waddr     = copy_addr_s1;
			mem.chr_wdata = chr_rdata;
		end
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				mem.chr_we    = 1'b1;
				mem.atr_we    = 1'b1;
				mem.waddr     = ptr_q;
				mem.chr_wdata = tcw_pkg::BLANK_CHAR;
				mem.atr_wdata = tcw_pkg::RESET_ATTR;
			end
			tcw_pkg::ST_IDLE: begin
				if (in_fire) begin
					unique case (req.kind)
						tcw_pkg::KIND_WRITE: begin
							if (!is_nl) begin
								mem.chr_we    = 1'b1;
								mem.atr_we    = 1'b1;
								mem.waddr     = cur_q;
								mem.chr_wdata = req.char_code;
								mem.atr_wdata = attr;
							end
							if (!scroll_w) begin
								res.load   = 1'b1;
								res.cursor = tcw_pkg::CUR_W'(wrap ? cur_nl : cur_inc);
							end
						end
						tcw_pkg::KIND_CLEAR: ;
						tcw_pkg::KIND_READ:  ;
						default: begin
							res.load   = 1'b1;
							res.cursor = tcw_pkg::CUR_W'(cur_q);
						end
					endcase
				end
			end
			tcw_pkg::ST_READ: begin
				res.load   = 1'b1;
				res.cursor = tcw_pkg::CUR_W'(cur_q);
				res.rchar  = oor_q ? '0 : chr_rdata;
				res.rattr  = oor_q ? '0 : atr_rdata;
			end
			tcw_pkg::ST_COPY: ;
			tcw_pkg::ST_BLANK: begin
				if (!copy_s1) begin
					mem.chr_we    = 1'b1;
					mem.atr_we    = 1'b1;
					mem.waddr     = ptr_q;
					mem.chr_wdata = tcw_pkg::BLANK_CHAR;
					mem.atr_wdata = attr;
					if (ptr_q == tcw_pkg::LAST_CELL) begin
						res.load     = 1'b1;
						res.cursor   = tcw_pkg::CUR_W'(cur_q);
						res.scrolled = scr_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tcw_pkg::ST_INIT;
			ptr_q        <= '0;
			cur_q        <= '0;
			col_q        <= '0;
			row_q        <= '0;
			scr_q        <= 1'b0;
			oor_q        <= 1'b0;
			copy_s1      <= 1'b0;
			copy_addr_s1 <= '0;
		end else begin
			state_q      <= state_d;
			copy_s1      <= (state_q == tcw_pkg::ST_COPY);
			copy_addr_s1 <= ptr_q - tcw_pkg::COLS_A;
			unique case (state_q)
				tcw_pkg::ST_INIT: ptr_q <= ptr_q + tcw_pkg::ADDR_W'(1);
				tcw_pkg::ST_IDLE: begin
					if (in_fire) begin
						unique case (req.kind)
							tcw_pkg::KIND_WRITE: begin
								if (scroll_w) begin
									ptr_q <= tcw_pkg::COLS_A;
									cur_q <= tcw_pkg::LAST_ROW_A;
									col_q <= '0;
									row_q <= tcw_pkg::ROW_LAST;
									scr_q <= 1'b1;
								end else if (wrap) begin
									cur_q <= cur_nl;
									col_q <= '0;
									row_q <= row_q + tcw_pkg::ROW_W'(1);
								end else begin
									cur_q <= cur_inc;
									col_q <= col_q + tcw_pkg::COL_W'(1);
								end
							end
							tcw_pkg::KIND_CLEAR: begin
								ptr_q <= '0;
								cur_q <= '0;
								col_q <= '0;
								row_q <= '0;
								scr_q <= 1'b0;
							end
							tcw_pkg::KIND_READ: oor_q <= !in_range;
							default: ;
						endcase
					end
				end
				tcw_pkg::ST_READ: ;
				tcw_pkg::ST_COPY: begin
					ptr_q <= (ptr_q == tcw_pkg::LAST_CELL) ? tcw_pkg::LAST_ROW_A
						: ptr_q + tcw_pkg::ADDR_W'(1);
				end
				tcw_pkg::ST_BLANK: begin
					if (!copy_s1) ptr_q <= ptr_q + tcw_pkg::ADDR_W'(1);
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/text_console_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Text console, 80x25 cells of character and attribute.
// Input channel (in_valid/in_stall): kind, char_code, cell_index. One request
// per item, one result per item on the output channel (out_valid/out_stall):
// cursor_position, read_char, read_attr, scrolled.
// Config channel (cfg_valid/cfg_ready, always ready): text attribute byte.
// A character write or unused kind loads the output register directly; a read
// first passes the registered memory read in state READ. A new request is taken
// every cycle for writes unless in_stall is high; READ keeps in_stall high.
// A write that scrolls copies character rows 1 to 24 up one row through the
// memory read and write ports, then blanks the bottom row. A clear blanks every
// cell. in_stall is high meanwhile. Reset: the memories are swept to blank
// with attribute 15, with in_stall high; configuration is accepted throughout.
// When the receiver stalls, the result holds in the output register and
// one more request is taken only as the result is drained.
module text_console_writer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   kind,
	input  wire logic [tcw_pkg::CHAR_W-1:0]   char_code,
	input  wire logic [tcw_pkg::CELL_W-1:0]   cell_index,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [tcw_pkg::CUR_W-1:0]    cursor_position,
	output logic      [tcw_pkg::CHAR_W-1:0]   read_char,
	output logic      [tcw_pkg::ATTR_W-1:0]   read_attr,
	output logic                              scrolled,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [tcw_pkg::ATTR_W-1:0]   cfg_data
);

	logic                        busy;
	logic                        in_fire;
	logic [tcw_pkg::ATTR_W-1:0]  attr_q;
	logic [tcw_pkg::CHAR_W-1:0]  chr_rdata;
	logic [tcw_pkg::ATTR_W-1:0]  atr_rdata;
	logic                        out_valid_q;
	tcw_pkg::req_t               req;
	tcw_pkg::mem_req_t           mem;
	tcw_pkg::result_t            res;

	assign req       = '{kind: kind, char_code: char_code, cell_index: cell_index};
	assign in_stall  = busy || (out_valid_q && out_stall);
	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::RESET_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= cfg_data;
		end
	end

	tcw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.in_fire   (in_fire),
		.attr      (attr_q),
		.chr_rdata (chr_rdata),
		.atr_rdata (atr_rdata),
		.busy      (busy),
		.mem       (mem),
		.res       (res)
	);

	tcw_ram #(
		.WIDTH (tcw_pkg::CHAR_W),
		.DEPTH (tcw_pkg::CELLS)
	) u_chr_ram (
		.clk   (clk),
		.we    (mem.chr_we),
		.waddr (mem.waddr),
		.wdata (mem.chr_wdata),
		.raddr (mem.raddr),
		.rdata (chr_rdata)
	);

	tcw_ram #(
		.WIDTH (tcw_pkg::ATTR_W),
		.DEPTH (tcw_pkg::CELLS)
	) u_atr_ram (
		.clk   (clk),
		.we    (mem.atr_we),
		.waddr (mem.waddr),
		.wdata (mem.atr_wdata),
		.raddr (mem.raddr),
		.rdata (atr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res.load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			cursor_position <= res.cursor;
			read_char       <= res.rchar;
			read_attr       <= res.rattr;
			scrolled        <= res.scrolled;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tcw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tcw_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_stall,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [tcw_pkg::CUR_W-1:0]  cursor_position,
	input wire logic [tcw_pkg::CHAR_W-1:0] read_char,
	input wire logic [tcw_pkg::ATTR_W-1:0] read_attr,
	input wire logic                       scrolled
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(cursor_position) < tcw_pkg::CELLS)
		else $error("cursor out of screen");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> int'(cursor_position) == tcw_pkg::LAST_ROW
			&& read_char == '0 && read_attr == '0)
		else $error("scroll result malformed");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("request taken while result blocked");

endmodule

bind text_console_writer tcw_checker u_chk (.*);
`default_nettype wire

// ===== tb/sv/text_console_writer_tb.sv =====
`timescale 1ns / 1ps
module text_console_writer_tb;
	import tcw_pkg::*;

	localparam logic [1:0] KIND_UNUSED    = 2'd3;
	localparam int         MAX_CELL_INDEX = (1 << CELL_W) - 1;
	localparam int         TARGET_ITEMS   = 1550;
	localparam int         PHASES         = 5;

	typedef struct packed {
		logic [CUR_W-1:0]  cursor;
		logic [CHAR_W-1:0] rchar;
		logic [ATTR_W-1:0] rattr;
		logic              scrolled;
	} console_out_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic [1:0]        kind       = '0;
	logic [CHAR_W-1:0] char_code  = '0;
	logic [CELL_W-1:0] cell_index = '0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [CUR_W-1:0]  cursor_position;
	logic [CHAR_W-1:0] read_char;
	logic [ATTR_W-1:0] read_attr;
	logic              scrolled;
	logic              cfg_valid  = 1'b0;
	logic              cfg_ready;
	logic [ATTR_W-1:0] cfg_data   = '0;

	logic [CHAR_W-1:0] shadow_char [CELLS];
	logic [ATTR_W-1:0] shadow_attr [CELLS];
	int unsigned       shadow_cursor;
	logic [ATTR_W-1:0] shadow_text_attr;

	console_out_t console_reports_q[$];
	console_out_t report_want;

	int failures      = 0;
	int requests_sent = 0;
	int read_count    = 0;
	int clear_count   = 0;
	int scroll_count  = 0;
	int attr_writes   = 0;
	int gap_pct       = 0;
	int stall_pct     = 0;

	text_console_writer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.char_code       (char_code),
		.cell_index      (cell_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cursor_position (cursor_position),
		.read_char       (read_char),
		.read_attr       (read_attr),
		.scrolled        (scrolled),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic console_out_t predict_console(input logic [1:0] k,
			input logic [CHAR_W-1:0] c, input logic [CELL_W-1:0] idx);
		console_out_t r;
		r = '0;
		if (shadow_cursor >= CELLS)
			shadow_cursor = 0;
		case (k)
			KIND_WRITE: begin
				if (c == NEWLINE_CODE) begin
					shadow_cursor = (shadow_cursor / COLUMNS + 1) * COLUMNS;
				end else begin
					shadow_char[shadow_cursor] = c;
					shadow_attr[shadow_cursor] = shadow_text_attr;
					shadow_cursor++;
				end
				if (shadow_cursor >= CELLS) begin
					// characters move up, attributes stay put
					for (int i = 0; i < LAST_ROW; i++)
						shadow_char[i] = shadow_char[i + COLUMNS];
					for (int i = LAST_ROW; i < CELLS; i++) begin
						shadow_char[i] = BLANK_CHAR;
						shadow_attr[i] = shadow_text_attr;
					end
					shadow_cursor = LAST_ROW;
					r.scrolled = 1'b1;
					scroll_count++;
				end
			end
			KIND_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					shadow_char[i] = BLANK_CHAR;
					shadow_attr[i] = shadow_text_attr;
				end
				shadow_cursor = 0;
				clear_count++;
			end
			KIND_READ: begin
				read_count++;
				if (idx < CELLS) begin
					r.rchar = shadow_char[idx];
					r.rattr = shadow_attr[idx];
				end
			end
			default: ;
		endcase
		r.cursor = CUR_W'(shadow_cursor);
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] text_char();
		logic [CHAR_W-1:0] c;
		c = CHAR_W'($urandom);
		if (c == NEWLINE_CODE)
			c = c ^ 8'h01;
		return c;
	endfunction

	task automatic send_request(input logic [1:0] k, input logic [CHAR_W-1:0] c,
			input logic [CELL_W-1:0] idx);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		char_code  <= c;
		cell_index <= idx;
		do @(posedge clk); while (in_stall !== 1'b0);
		console_reports_q.push_back(predict_console(k, c, idx));
		requests_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (console_reports_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_attribute(input logic [ATTR_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		shadow_text_attr = value;
		attr_writes++;
	endtask

	task automatic test_reset_contents();
		gap_pct   = 20;
		stall_pct = 20;
		send_request(KIND_READ, 8'h00, CELL_W'(0));
		send_request(KIND_READ, 8'hff, CELL_W'(CELLS - 1));
		send_request(KIND_READ, 8'h00, CELL_W'(CELLS));
		send_request(KIND_READ, 8'h00, CELL_W'(MAX_CELL_INDEX));
	endtask

	task automatic test_attribute_extremes();
		drain_results();
		write_attribute(8'h00);
		send_request(KIND_WRITE, 8'h00, CELL_W'(0));
		drain_results();
		write_attribute(8'hff);
		send_request(KIND_WRITE, 8'hff, CELL_W'(MAX_CELL_INDEX));
		send_request(KIND_READ, 8'h00, CELL_W'(0));
		send_request(KIND_READ, 8'h00, CELL_W'(1));
		send_request(KIND_READ, 8'h00, CELL_W'(2));
	endtask

	task automatic test_newline_and_unused_kind();
		send_request(KIND_WRITE, NEWLINE_CODE, CELL_W'(0));
		send_request(KIND_WRITE, 8'h41, CELL_W'(0));
		send_request(KIND_UNUSED, NEWLINE_CODE, CELL_W'(0));
		send_request(KIND_UNUSED, 8'hff, CELL_W'(MAX_CELL_INDEX));
		send_request(KIND_READ, 8'h00, CELL_W'(COLUMNS));
		send_request(KIND_READ, 8'h00, CELL_W'(COLUMNS + 1));
	endtask

	task automatic test_clear();
		send_request(KIND_CLEAR, 8'hff, CELL_W'(MAX_CELL_INDEX));
		send_request(KIND_READ, 8'h00, CELL_W'(0));
		send_request(KIND_READ, 8'h00, CELL_W'(COLUMNS));
		send_request(KIND_READ, 8'h00, CELL_W'(CELLS - 1));
		drain_results();
		write_attribute(RESET_ATTR);
	endtask

	// walk down to the bottom row; the last newline scrolls
	task automatic test_bottom_row_scroll();
		for (int r = 0; r < ROWS; r++) begin
			repeat ($urandom_range(0, 3))
				send_request(KIND_WRITE, text_char(), CELL_W'($urandom));
			send_request(KIND_WRITE, NEWLINE_CODE, CELL_W'($urandom));
		end
		repeat (6)
			send_request(KIND_READ, CHAR_W'($urandom),
				CELL_W'($urandom_range(LAST_ROW - 2 * COLUMNS, CELLS - 1)));
	endtask

	task automatic test_random_traffic();
		int phase_end;
		int pick;
		int sel;
		int off;
		int n;
		logic [CELL_W-1:0] read_cell;
		for (int phase = 0; phase < PHASES; phase++) begin
			phase_end = requests_sent + (TARGET_ITEMS - requests_sent) / (PHASES - phase);
			drain_results();
			case (phase)
				1: write_attribute(8'h00);
				2: write_attribute(8'hff);
				default: write_attribute(ATTR_W'($urandom));
			endcase
			case (phase)
				0: begin gap_pct = 20; stall_pct = 20; end
				1: begin gap_pct = 0;  stall_pct = 35; end
				2: begin gap_pct = 35; stall_pct = 0;  end
				3: begin gap_pct = 10; stall_pct = 10; end
				default: begin gap_pct = 0; stall_pct = 0; end
			endcase
			while (requests_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
						: $urandom_range(1, 12);
					repeat (n)
						send_request(KIND_WRITE, text_char(), CELL_W'($urandom));
					if ($urandom_range(0, 9) < 6)
						send_request(KIND_WRITE, NEWLINE_CODE, CELL_W'($urandom));
				end else if (pick < 63) begin
					repeat ($urandom_range(1, 5))
						send_request(KIND_WRITE, NEWLINE_CODE, CELL_W'($urandom));
				end else if (pick < 83) begin
					repeat ($urandom_range(1, 6)) begin
						sel = $urandom_range(0, 99);
						off = $urandom_range(1, COLUMNS + 1);
						if (sel < 50)
							read_cell = (shadow_cursor >= off)
								? CELL_W'(shadow_cursor - off)
								: CELL_W'($urandom_range(0, COLUMNS - 1));
						else if (sel < 75)
							read_cell = CELL_W'($urandom_range(0, CELLS - 1));
						else if (sel < 85)
							read_cell = CELL_W'($urandom_range(LAST_ROW, CELLS - 1));
						else
							read_cell = CELL_W'($urandom_range(CELLS, MAX_CELL_INDEX));
						send_request(KIND_READ, CHAR_W'($urandom), read_cell);
					end
				end else if (pick < 93) begin
					repeat ($urandom_range(1, 3))
						send_request(KIND_UNUSED, CHAR_W'($urandom), CELL_W'($urandom));
				end else if (pick < 94) begin
					send_request(KIND_CLEAR, CHAR_W'($urandom), CELL_W'($urandom));
				end else begin
					send_request(2'($urandom), CHAR_W'($urandom), CELL_W'($urandom));
				end
			end
		end
	endtask

	always begin
		@(posedge clk);
		if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (console_reports_q.size() == 0) begin
				$error("unexpected result: cursor_position %0d", cursor_position);
				failures++;
			end else begin
				report_want = console_reports_q.pop_front();
				if (cursor_position !== report_want.cursor) begin
					$error("cursor_position: expected %0d, got %0d",
						report_want.cursor, cursor_position);
					failures++;
				end
				if (read_char !== report_want.rchar) begin
					$error("read_char: expected %0d, got %0d", report_want.rchar, read_char);
					failures++;
				end
				if (read_attr !== report_want.rattr) begin
					$error("read_attr: expected %0d, got %0d", report_want.rattr, read_attr);
					failures++;
				end
				if (scrolled !== report_want.scrolled) begin
					$error("scrolled: expected %0d, got %0d", report_want.scrolled, scrolled);
					failures++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < CELLS; i++) begin
			shadow_char[i] = BLANK_CHAR;
			shadow_attr[i] = RESET_ATTR;
		end
		shadow_cursor    = 0;
		shadow_text_attr = RESET_ATTR;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_contents();
		test_attribute_extremes();
		test_newline_and_unused_kind();
		test_clear();
		test_bottom_row_scroll();
		test_random_traffic();
		drain_results();
		repeat (10) @(posedge clk);
		$display("Console saw %0d requests: %0d cell reads, %0d clears, %0d scrolls.",
			requests_sent, read_count, clear_count, scroll_count);
		$display("Text attribute set %0d times, both extremes included.", attr_writes);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== text_console_writer.f =====
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_seq.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
tb/sv/text_console_writer_tb.sv
